[hdl/rau_pkg.sv]
package rau_pkg;

	localparam int W  = 32;
	localparam int DW = 2 * W;
	localparam int KW = $clog2(DW) + 1;

	localparam logic [3:0] OP_NORM = 4'd0;
	localparam logic [3:0] OP_ADD  = 4'd1;
	localparam logic [3:0] OP_SUB  = 4'd2;
	localparam logic [3:0] OP_MUL  = 4'd3;
	localparam logic [3:0] OP_DIV  = 4'd4;
	localparam logic [3:0] OP_NEG  = 4'd5;
	localparam logic [3:0] OP_LT   = 4'd6;
	localparam logic [3:0] OP_EQ   = 4'd7;
	localparam logic [3:0] OP_GT   = 4'd8;
	localparam logic [3:0] OP_LE   = 4'd9;
	localparam logic [3:0] OP_GE   = 4'd10;
	localparam logic [3:0] OP_NE   = 4'd11;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_ZERODEN = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_MUL  = 7'b0000010,
		S_ADD  = 7'b0000100,
		S_CHK  = 7'b0001000,
		S_GCD  = 7'b0010000,
		S_DIV  = 7'b0100000,
		S_FIN  = 7'b1000000
	} state_t;

	typedef struct packed {
		logic start;
		logic mul;
		logic add;
		logic gcd_init;
		logic gcd_step;
		logic div_init;
		logic div_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic early;
		logic gcd_done;
		logic div_done;
	} stat_t;

endpackage

[hdl/rational_arithmetic_unit_core.sv]
// Rational arithmetic unit: one item at a time through a controller and a shared datapath.
// Comparisons and operations with a zero denominator skip the gcd and divide steps.
// Arithmetic adds the binary gcd loop (one step per cycle) and 64 restoring division steps
// before the finish state. A new item is accepted only while the controller is idle;
// a finished result may wait. arst_n clears the controller and the output valid only.
module rational_arithmetic_unit_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [3:0]                   opcode,
	input  logic signed [rau_pkg::W-1:0] a_num,
	input  logic signed [rau_pkg::W-1:0] a_den,
	input  logic signed [rau_pkg::W-1:0] b_num,
	input  logic signed [rau_pkg::W-1:0] b_den,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [rau_pkg::W-1:0] res_num,
	output logic [rau_pkg::W-2:0]        res_den,
	output logic                         cmp_true,
	output logic [1:0]                   status
);

	// The controller sequences the item through multiply, add, gcd and divide steps.
	rau_pkg::cmd_t  cmd;
	rau_pkg::stat_t stat;

	rau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The datapath holds operands, products, the gcd and quotient registers and the result.
	rau_dp u_dp (
		.clk      (clk),
		.cmd      (cmd),
		.stat     (stat),
		.opcode   (opcode),
		.a_num    (a_num),
		.a_den    (a_den),
		.b_num    (b_num),
		.b_den    (b_den),
		.res_num  (res_num),
		.res_den  (res_den),
		.cmp_true (cmp_true),
		.status   (status)
	);

endmodule

[hdl/rau_ctrl.sv]
module rau_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  rau_pkg::stat_t stat,
	output rau_pkg::cmd_t  cmd
);

	rau_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic can_load;

	assign in_stall  = (state_q != rau_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign can_load  = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			rau_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = rau_pkg::S_MUL;
				end
			end
			rau_pkg::S_MUL: begin
				cmd.mul = 1'b1;
				state_d = rau_pkg::S_ADD;
			end
			rau_pkg::S_ADD: begin
				cmd.add = 1'b1;
				state_d = rau_pkg::S_CHK;
			end
			rau_pkg::S_CHK: begin
				if (stat.early) begin
					state_d = rau_pkg::S_FIN;
				end else begin
					cmd.gcd_init = 1'b1;
					state_d      = rau_pkg::S_GCD;
				end
			end
			rau_pkg::S_GCD: begin
				if (stat.gcd_done) begin
					cmd.div_init = 1'b1;
					state_d      = rau_pkg::S_DIV;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			rau_pkg::S_DIV: begin
				if (stat.div_done) begin
					state_d = rau_pkg::S_FIN;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			rau_pkg::S_FIN: begin
				if (can_load) begin
					cmd.load_out = 1'b1;
					state_d      = rau_pkg::S_IDLE;
				end
			end
			default: state_d = rau_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rau_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[hdl/rau_dp.sv]
module rau_dp (
	input  logic                        clk,
	input  rau_pkg::cmd_t               cmd,
	output rau_pkg::stat_t              stat,
	input  logic [3:0]                  opcode,
	input  logic signed [rau_pkg::W-1:0] a_num,
	input  logic signed [rau_pkg::W-1:0] a_den,
	input  logic signed [rau_pkg::W-1:0] b_num,
	input  logic signed [rau_pkg::W-1:0] b_den,
	output logic signed [rau_pkg::W-1:0] res_num,
	output logic [rau_pkg::W-2:0]       res_den,
	output logic                        cmp_true,
	output logic [1:0]                  status
);

	localparam int W  = rau_pkg::W;
	localparam int DW = rau_pkg::DW;
	localparam int KW = rau_pkg::KW;

	function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
		return v[W-1] ? (~v + 1'b1) : v;
	endfunction

	logic [3:0]    op_q;
	logic          an_s_q, ad_s_q, bn_s_q, bd_s_q, eq_q;
	logic [W-1:0]  an_q, ad_q, bn_q, bd_q;
	logic [DW-1:0] x_q, y_q, dd_q, nn_q;
	logic          num_s_q, den_s_q, lt_q, gt_q;
	logic [DW-1:0] num_q, den_q;
	logic [DW-1:0] u_q, v_q, g_q;
	logic [KW-1:0] k_q, cnt_q;
	logic [DW:0]   rn_q, rd_q;
	logic [DW-1:0] qn_q, qd_q;
	logic          is_arith;
	logic          zden;

	logic          xs, ys, sum_s, nsel_s, dsel_s;
	logic [DW-1:0] sum_m, nsel_m, dsel_m;
	logic signed [DW-1:0] xv, yv;
	logic [DW:0]   rn_sh, rd_sh;
	logic          rneg, fit_bad, cmp_sel;

	always_comb begin
		is_arith = 1'b0;
		case (op_q) inside
			rau_pkg::OP_NORM, rau_pkg::OP_ADD, rau_pkg::OP_SUB,
			rau_pkg::OP_MUL, rau_pkg::OP_DIV, rau_pkg::OP_NEG: is_arith = 1'b1;
			default: is_arith = 1'b0;
		endcase
	end

	// Signed sum of the two cross products.
	always_comb begin
		xs = an_s_q ^ bd_s_q;
		ys = bn_s_q ^ ad_s_q ^ (op_q == rau_pkg::OP_SUB);
		if (xs == ys) begin
			sum_s = xs;
			sum_m = x_q + y_q;
		end else if (x_q >= y_q) begin
			sum_s = xs;
			sum_m = x_q - y_q;
		end else begin
			sum_s = ys;
			sum_m = y_q - x_q;
		end
		xv = xs ? -$signed(x_q) : $signed(x_q);
		yv = (bn_s_q ^ ad_s_q) ? -$signed(y_q) : $signed(y_q);
	end

	always_comb begin
		nsel_s = an_s_q;
		nsel_m = DW'(an_q);
		dsel_s = ad_s_q;
		dsel_m = DW'(ad_q);
		unique case (op_q)
			rau_pkg::OP_NEG: nsel_s = !an_s_q;
			rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
				nsel_s = sum_s;
				nsel_m = sum_m;
				dsel_s = ad_s_q ^ bd_s_q;
				dsel_m = dd_q;
			end
			rau_pkg::OP_MUL: begin
				nsel_s = an_s_q ^ bn_s_q;
				nsel_m = nn_q;
				dsel_s = ad_s_q ^ bd_s_q;
				dsel_m = dd_q;
			end
			rau_pkg::OP_DIV: begin
				nsel_s = an_s_q ^ bd_s_q;
				nsel_m = x_q;
				dsel_s = ad_s_q ^ bn_s_q;
				dsel_m = y_q;
			end
			default: ;
		endcase
	end

	assign rn_sh = {rn_q[DW-1:0], qn_q[DW-1]};
	assign rd_sh = {rd_q[DW-1:0], qd_q[DW-1]};

	// A division also fails on a zero divisor denominator, which the product misses.
	assign zden = (den_q == '0) || ((op_q == rau_pkg::OP_DIV) && (bd_q == '0));

	assign stat.early    = !is_arith || zden;
	assign stat.gcd_done = (u_q == '0) || (v_q == '0);
	assign stat.div_done = cnt_q[KW-1];

	always_comb begin
		rneg    = (qn_q != '0) && (num_s_q != den_s_q);
		fit_bad = (qd_q[DW-1:W-1] != '0) ||
			(rneg ? (qn_q > (DW'(1) << (W-1))) : (qn_q[DW-1:W-1] != '0));
		cmp_sel = 1'b0;
		case (op_q)
			rau_pkg::OP_LT: cmp_sel = lt_q;
			rau_pkg::OP_EQ: cmp_sel = eq_q;
			rau_pkg::OP_GT: cmp_sel = gt_q;
			rau_pkg::OP_LE: cmp_sel = !gt_q;
			rau_pkg::OP_GE: cmp_sel = !lt_q;
			rau_pkg::OP_NE: cmp_sel = !eq_q;
			default:        cmp_sel = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q   <= opcode;
			an_s_q <= a_num[W-1];
			ad_s_q <= a_den[W-1];
			bn_s_q <= b_num[W-1];
			bd_s_q <= b_den[W-1];
			an_q   <= mag_of(a_num);
			ad_q   <= mag_of(a_den);
			bn_q   <= mag_of(b_num);
			bd_q   <= mag_of(b_den);
			eq_q   <= (a_num == b_num) && (a_den == b_den);
		end
		if (cmd.mul) begin
			x_q  <= DW'(an_q) * DW'(bd_q);
			y_q  <= DW'(bn_q) * DW'(ad_q);
			dd_q <= DW'(ad_q) * DW'(bd_q);
			nn_q <= DW'(an_q) * DW'(bn_q);
		end
		if (cmd.add) begin
			num_s_q <= nsel_s;
			num_q   <= nsel_m;
			den_s_q <= dsel_s;
			den_q   <= dsel_m;
			lt_q    <= xv < yv;
			gt_q    <= yv < xv;
		end
		if (cmd.gcd_init) begin
			u_q <= num_q;
			v_q <= den_q;
			k_q <= '0;
		end else if (cmd.gcd_step) begin
			if (!u_q[0] && !v_q[0]) begin
				u_q <= u_q >> 1;
				v_q <= v_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else if (u_q >= v_q) begin
				u_q <= u_q - v_q;
			end else begin
				v_q <= v_q - u_q;
			end
		end
		if (cmd.div_init) begin
			g_q   <= (u_q | v_q) << k_q;
			rn_q  <= '0;
			rd_q  <= '0;
			qn_q  <= num_q;
			qd_q  <= den_q;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 1'b1;
			if (rn_sh >= {1'b0, g_q}) begin
				rn_q <= rn_sh - {1'b0, g_q};
				qn_q <= {qn_q[DW-2:0], 1'b1};
			end else begin
				rn_q <= rn_sh;
				qn_q <= {qn_q[DW-2:0], 1'b0};
			end
			if (rd_sh >= {1'b0, g_q}) begin
				rd_q <= rd_sh - {1'b0, g_q};
				qd_q <= {qd_q[DW-2:0], 1'b1};
			end else begin
				rd_q <= rd_sh;
				qd_q <= {qd_q[DW-2:0], 1'b0};
			end
		end
		if (cmd.load_out) begin
			res_num  <= '0;
			res_den  <= '0;
			cmp_true <= 1'b0;
			status   <= rau_pkg::ST_OK;
			if (!is_arith) begin
				cmp_true <= cmp_sel;
			end else if (zden) begin
				status <= rau_pkg::ST_ZERODEN;
			end else if (fit_bad) begin
				status <= rau_pkg::ST_RANGE;
			end else begin
				res_num <= rneg ? -$signed(qn_q[W-1:0]) : $signed(qn_q[W-1:0]);
				res_den <= qd_q[W-2:0];
			end
		end
	end

endmodule
